### rtl/uicp_pkg.sv
// ----------------------------------------------------------------------------
// Configuration port package
// Shared constants: port decode, command codes, register map.
// ----------------------------------------------------------------------------
package uicp_pkg;

	localparam int unsigned CfgDepth = 256;
	localparam int unsigned CfgWidth = 8;
	localparam int unsigned CfgAddrW = $clog2(CfgDepth);

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [1:0] PORT_INDEX  = 2'd0;
	localparam logic [1:0] PORT_UNLOCK = 2'd1;
	localparam logic [1:0] PORT_DATA   = 2'd2;

	localparam logic [CfgAddrW-1:0] REG_SHADOW_EF = 8'h00;
	localparam logic [CfgAddrW-1:0] REG_BIOS_WR   = 8'h08;
	localparam logic [CfgAddrW-1:0] REG_BASE_MEM  = 8'h12;
	localparam logic [CfgAddrW-1:0] REG_SMRAM     = 8'h1B;
	localparam logic [CfgAddrW-1:0] REG_SHADOW_C  = 8'h1C;
	localparam logic [CfgAddrW-1:0] REG_IRQ_B     = 8'h1D;
	localparam logic [CfgAddrW-1:0] REG_IRQ_C     = 8'h1E;
	localparam logic [CfgAddrW-1:0] REG_IRQ_D     = 8'h21;

	localparam logic [CfgWidth-1:0] DATA_UNARMED = 8'hFF;

endpackage

### rtl/uicp_req_if.sv
// ----------------------------------------------------------------------------
// Access request channel
// Valid/ready channel carrying one I/O access per item.
// ----------------------------------------------------------------------------
interface uicp_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [1:0] io_port;
	logic [7:0] write_data;

	modport source (output valid, cmd, io_port, write_data, input ready);
	modport sink   (input valid, cmd, io_port, write_data, output ready);
endinterface

### rtl/uicp_rsp_if.sv
// ----------------------------------------------------------------------------
// Access result channel
// Valid/ready channel carrying read data and decoded chipset controls.
// ----------------------------------------------------------------------------
interface uicp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [1:0] shadow_ef_read;
	logic       bios_shadow_write;
	logic [3:0] shadow_c_read;
	logic [3:0] shadow_d_read;
	logic       base_memory_512k;
	logic       smram_enabled;
	logic       smi_request;
	logic [3:0] irq_route_a;
	logic [3:0] irq_route_b;
	logic [3:0] irq_route_c;
	logic [3:0] irq_route_d;

	modport source (output valid, read_data, shadow_ef_read, bios_shadow_write,
		shadow_c_read, shadow_d_read, base_memory_512k, smram_enabled, smi_request,
		irq_route_a, irq_route_b, irq_route_c, irq_route_d, input ready);
	modport sink   (input valid, read_data, shadow_ef_read, bios_shadow_write,
		shadow_c_read, shadow_d_read, base_memory_512k, smram_enabled, smi_request,
		irq_route_a, irq_route_b, irq_route_c, irq_route_d, output ready);
endinterface

### rtl/uicp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module uicp_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 256,
	parameter int unsigned AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/unlocked_index_config_port_core.sv
// ----------------------------------------------------------------------------
// Indexed configuration port with unlock
// Index, unlock and data ports in front of a 256-byte register file.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one I/O access per item (cmd, io_port, write_data); rsp
//   returns one result per item with the read byte and the controls decoded
//   from the register file as it stands after the access.
//   An item taken at one edge is offered on rsp from the cycle after that
//   edge. One item is taken every cycle while rsp is not stalled;
//   the register file RAM is written and read at the accepting edge, so a
//   data access right behind a write sees the new byte.
//   The result register holds while rsp.ready is low, and req.ready falls
//   until it is taken.
//   Reset clears the index, the unlock state and the decoded controls; a
//   flag per register marks bytes written since reset, unwritten bytes read
//   as zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module unlocked_index_config_port_core import uicp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	uicp_req_if.sink     req,
	uicp_rsp_if.source   rsp
);

	logic                acc;
	logic                data_wr;
	logic                data_rd;
	logic [CfgAddrW-1:0] index_q;
	logic                armed_q;
	logic [CfgDepth-1:0] ent_vld_q;
	logic [CfgWidth-1:0] swapped;
	logic [CfgWidth-1:0] ram_rdata;
	logic [CfgWidth-1:0] rdata_nxt;

	logic [1:0] ef_q;
	logic       bios_q;
	logic       base_q;
	logic       smram_q;
	logic       smi_bit_q;
	logic [3:0] d_q;
	logic [3:0] c_q;
	logic [3:0] irqa_q;
	logic [3:0] irqb_q;
	logic [3:0] irqc_q;
	logic [3:0] irqd_q;

	logic                vld_s1;
	logic                smi_s1;
	logic                ram_sel_s1;
	logic                ent_s1;
	logic [CfgWidth-1:0] rdata_s1;

	assign req.ready = !vld_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign swapped   = {index_q[3:0], index_q[7:4]};
	assign data_wr   = acc && req.cmd == CMD_WRITE && req.io_port == PORT_DATA && armed_q;
	assign data_rd   = acc && req.cmd == CMD_READ && req.io_port == PORT_DATA && armed_q;

	always_comb begin
		rdata_nxt = '0;
		if (req.cmd == CMD_READ) begin
			case (req.io_port)
				PORT_INDEX:  rdata_nxt = index_q;
				PORT_UNLOCK: rdata_nxt = swapped;
				default:     rdata_nxt = DATA_UNARMED;
			endcase
		end
	end

	uicp_ram #(
		.Width (CfgWidth),
		.Depth (CfgDepth)
	) u_cfg_ram (
		.clk   (clk),
		.we    (data_wr),
		.waddr (index_q),
		.wdata (req.write_data),
		.re    (data_rd),
		.raddr (index_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q   <= '0;
			armed_q   <= 1'b0;
			ent_vld_q <= '0;
			ef_q      <= '0;
			bios_q    <= 1'b0;
			base_q    <= 1'b0;
			smram_q   <= 1'b0;
			smi_bit_q <= 1'b0;
			d_q       <= '0;
			c_q       <= '0;
			irqa_q    <= '0;
			irqb_q    <= '0;
			irqc_q    <= '0;
			irqd_q    <= '0;
			vld_s1    <= 1'b0;
			smi_s1    <= 1'b0;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
				smi_s1 <= data_wr && index_q == REG_SMRAM && !smi_bit_q
					&& req.write_data[4];
			end else if (rsp.ready) begin
				vld_s1 <= 1'b0;
			end
			if (acc && req.cmd == CMD_WRITE && req.io_port == PORT_INDEX) begin
				index_q <= req.write_data;
			end
			if (acc && req.cmd == CMD_WRITE && req.io_port == PORT_UNLOCK
				&& req.write_data == swapped) begin
				armed_q <= 1'b1;
			end
			if (data_wr || data_rd) begin
				armed_q <= 1'b0;
			end
			if (data_wr) begin
				ent_vld_q[index_q] <= 1'b1;
				case (index_q)
					REG_SHADOW_EF: ef_q   <= req.write_data[3:2];
					REG_BIOS_WR:   bios_q <= req.write_data[2];
					REG_BASE_MEM:  base_q <= req.write_data[1];
					REG_SMRAM: begin
						smram_q   <= req.write_data[6];
						smi_bit_q <= req.write_data[4];
						d_q       <= req.write_data[3:0];
					end
					REG_SHADOW_C: begin
						c_q    <= req.write_data[3:0];
						irqa_q <= req.write_data[7:4];
					end
					REG_IRQ_B:     irqb_q <= req.write_data[7:4];
					REG_IRQ_C:     irqc_q <= req.write_data[7:4];
					REG_IRQ_D:     irqd_q <= req.write_data[7:4];
					default:       ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1   <= rdata_nxt;
			ram_sel_s1 <= data_rd;
			ent_s1     <= ent_vld_q[index_q];
		end
	end

	assign rsp.valid             = vld_s1;
	assign rsp.read_data         = ram_sel_s1 ? (ent_s1 ? ram_rdata : '0) : rdata_s1;
	assign rsp.shadow_ef_read    = ef_q;
	assign rsp.bios_shadow_write = bios_q;
	assign rsp.shadow_c_read     = c_q;
	assign rsp.shadow_d_read     = d_q;
	assign rsp.base_memory_512k  = base_q;
	assign rsp.smram_enabled     = smram_q;
	assign rsp.smi_request       = smi_s1;
	assign rsp.irq_route_a       = irqa_q;
	assign rsp.irq_route_b       = irqb_q;
	assign rsp.irq_route_c       = irqc_q;
	assign rsp.irq_route_d       = irqd_q;

	a_data_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(data_wr || data_rd) |=> !armed_q)
		else $error("data access left the port armed");

	a_unarmed_read_ff: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.cmd == CMD_READ && req.io_port == PORT_DATA && !armed_q)
		|=> rsp.read_data == DATA_UNARMED)
		else $error("unarmed data read did not return all ones");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.cmd == CMD_WRITE) |=> rsp.read_data == '0)
		else $error("write item returned non-zero read data");

	a_smi_bit_set: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.smi_request) |-> smi_bit_q)
		else $error("software SMI raised without the trigger bit set");

endmodule

### tb/uicp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Configuration port checker
// Watches the access and result channels, keeps its own copy of the index,
// unlock state and register file, works out the result of every accepted
// access and compares each returned result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module uicp_checker import uicp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	uicp_req_if  req,
	uicp_rsp_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   result_count,
	output int   smi_count,
	output int   unlock_count
);

	localparam int SMI_BIT   = 4;
	localparam int SMRAM_BIT = 6;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] shadow_ef_read;
		logic       bios_shadow_write;
		logic [3:0] shadow_c_read;
		logic [3:0] shadow_d_read;
		logic       base_memory_512k;
		logic       smram_enabled;
		logic       smi_request;
		logic [3:0] irq_route_a;
		logic [3:0] irq_route_b;
		logic [3:0] irq_route_c;
		logic [3:0] irq_route_d;
	} port_result_t;

	logic [CfgWidth-1:0] cfg_mem [CfgDepth];
	logic [CfgAddrW-1:0] cur_index;
	logic                armed;
	port_result_t        result_q [$];
	int                  fails;
	int                  results;
	int                  smis;
	int                  unlocks;

	function automatic port_result_t predict_access(logic cmd, logic [1:0] port,
		logic [7:0] wdata);
		port_result_t r;
		logic [7:0]   swapped;
		swapped = {cur_index[3:0], cur_index[7:4]};
		r = '0;
		if (cmd == CMD_WRITE) begin
			case (port)
				PORT_INDEX: cur_index = wdata;
				PORT_UNLOCK: begin
					if (wdata == swapped)
						armed = 1'b1;
				end
				PORT_DATA: begin
					if (armed) begin
						r.smi_request = (cur_index == REG_SMRAM) &&
							!cfg_mem[cur_index][SMI_BIT] && wdata[SMI_BIT];
						cfg_mem[cur_index] = wdata;
						armed = 1'b0;
						unlocks++;
					end
				end
				default: ;
			endcase
		end else begin
			case (port)
				PORT_INDEX:  r.read_data = cur_index;
				PORT_UNLOCK: r.read_data = swapped;
				PORT_DATA: begin
					if (armed) begin
						r.read_data = cfg_mem[cur_index];
						armed = 1'b0;
						unlocks++;
					end else begin
						r.read_data = DATA_UNARMED;
					end
				end
				default: r.read_data = DATA_UNARMED;
			endcase
		end
		r.shadow_ef_read    = cfg_mem[REG_SHADOW_EF][3:2];
		r.bios_shadow_write = cfg_mem[REG_BIOS_WR][2];
		r.shadow_c_read     = cfg_mem[REG_SHADOW_C][3:0];
		r.shadow_d_read     = cfg_mem[REG_SMRAM][3:0];
		r.base_memory_512k  = cfg_mem[REG_BASE_MEM][1];
		r.smram_enabled     = cfg_mem[REG_SMRAM][SMRAM_BIT];
		r.irq_route_a       = cfg_mem[REG_SHADOW_C][7:4];
		r.irq_route_b       = cfg_mem[REG_IRQ_B][7:4];
		r.irq_route_c       = cfg_mem[REG_IRQ_C][7:4];
		r.irq_route_d       = cfg_mem[REG_IRQ_D][7:4];
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		port_result_t want;
		port_result_t next;
		if (!arst_n) begin
			cur_index = '0;
			armed     = 1'b0;
			foreach (cfg_mem[i])
				cfg_mem[i] = '0;
			result_q.delete();
			fails   = 0;
			results = 0;
			smis    = 0;
			unlocks = 0;
			fail_count   <= 0;
			pending      <= 0;
			result_count <= 0;
			smi_count    <= 0;
			unlock_count <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					fails++;
					$display("%0t: result with no access outstanding", $time);
				end else begin
					want = result_q.pop_front();
					check_field("read_data", want.read_data, rsp.read_data);
					check_field("shadow_ef_read", want.shadow_ef_read, rsp.shadow_ef_read);
					check_field("bios_shadow_write", want.bios_shadow_write,
						rsp.bios_shadow_write);
					check_field("shadow_c_read", want.shadow_c_read, rsp.shadow_c_read);
					check_field("shadow_d_read", want.shadow_d_read, rsp.shadow_d_read);
					check_field("base_memory_512k", want.base_memory_512k,
						rsp.base_memory_512k);
					check_field("smram_enabled", want.smram_enabled, rsp.smram_enabled);
					check_field("smi_request", want.smi_request, rsp.smi_request);
					check_field("irq_route_a", want.irq_route_a, rsp.irq_route_a);
					check_field("irq_route_b", want.irq_route_b, rsp.irq_route_b);
					check_field("irq_route_c", want.irq_route_c, rsp.irq_route_c);
					check_field("irq_route_d", want.irq_route_d, rsp.irq_route_d);
				end
				results++;
			end
			if (req.valid && req.ready) begin
				next = predict_access(req.cmd, req.io_port, req.write_data);
				if (next.smi_request)
					smis++;
				result_q.push_back(next);
			end
			fail_count   <= fails;
			pending      <= result_q.size();
			result_count <= results;
			smi_count    <= smis;
			unlock_count <= unlocks;
		end
	end

endmodule

### tb/unlocked_index_config_port_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Configuration port testbench
// Drives index, unlock and data accesses into the port: a directed opening
// over the special cases, then mostly well-formed unlock sequences aimed at
// the decoded control registers, mixed with noise. Both channels idle in
// random bursts; the result side also holds off for one long stretch.
// ----------------------------------------------------------------------------
module unlocked_index_config_port_core_test;
	import uicp_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int HOLD_CYCLES  = 80;
	localparam int RANDOM_ITEMS = 420;
	localparam int QUIET_ITEMS  = 360;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   result_count;
	int   smi_count;
	int   unlock_count;
	int   items_sent;
	int   cycles = 0;
	bit   idle_on;
	bit   hold_rsp;

	uicp_req_if req ();
	uicp_rsp_if rsp ();

	unlocked_index_config_port_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	uicp_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count),
		.smi_count    (smi_count),
		.unlock_count (unlock_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_item(logic cmd, logic [1:0] port, logic [7:0] data);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.cmd        <= cmd;
		req.io_port    <= port;
		req.write_data <= data;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic arm_access(logic [7:0] idx);
		send_item(CMD_WRITE, PORT_INDEX, idx);
		send_item(CMD_WRITE, PORT_UNLOCK, {idx[3:0], idx[7:4]});
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (result_count != items_sent) @(posedge clk);
	endtask

	task automatic run_sequence();
		logic [7:0] idx;
		logic [7:0] key;
		int         kind;
		int         pick;
		kind = $urandom_range(0, 9);
		pick = $urandom_range(0, 9);
		case (pick)
			0: idx = REG_SHADOW_EF;
			1: idx = REG_BIOS_WR;
			2: idx = REG_BASE_MEM;
			3, 4: idx = REG_SMRAM;
			5: idx = REG_SHADOW_C;
			6: idx = REG_IRQ_B;
			7: idx = REG_IRQ_C;
			8: idx = REG_IRQ_D;
			default: idx = 8'($urandom_range(0, 255));
		endcase
		key = {idx[3:0], idx[7:4]};
		if (kind <= 6) begin
			send_item(CMD_WRITE, PORT_INDEX, idx);
			if ($urandom_range(0, 3) == 0)
				send_item(CMD_READ, 2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			send_item(CMD_WRITE, PORT_UNLOCK, key);
			if ($urandom_range(0, 5) == 0)
				send_item(CMD_WRITE, PORT_UNLOCK, key ^ 8'($urandom_range(1, 255)));
			if ($urandom_range(0, 9) < 6)
				send_item(CMD_WRITE, PORT_DATA, 8'($urandom_range(0, 255)));
			else
				send_item(CMD_READ, PORT_DATA, 8'($urandom_range(0, 255)));
		end else if (kind == 7) begin
			send_item(CMD_WRITE, PORT_INDEX, idx);
			send_item(CMD_WRITE, PORT_UNLOCK, key ^ 8'($urandom_range(1, 255)));
			send_item(1'($urandom_range(0, 1)), PORT_DATA, 8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 3))
				send_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)));
		end
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		rsp.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_rsp && !hold_done) begin
				hold_done = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.cmd        = CMD_READ;
		req.io_port    = PORT_INDEX;
		req.write_data = '0;
		items_sent     = 0;
		idle_on        = 1'b1;
		hold_rsp       = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads straight out of reset, undecoded port
		send_item(CMD_READ, PORT_INDEX, 8'h00);
		send_item(CMD_READ, PORT_UNLOCK, 8'hFF);
		send_item(CMD_READ, PORT_DATA, 8'h00);
		send_item(CMD_READ, 2'd3, 8'h00);
		send_item(CMD_WRITE, 2'd3, 8'hAA);
		// SMI pulse, SMRAM and D segment shadow
		arm_access(REG_SMRAM);
		send_item(CMD_WRITE, PORT_DATA, 8'h5F);
		// wrong key leaves the port locked; unarmed write is dropped
		send_item(CMD_WRITE, PORT_UNLOCK, 8'h00);
		send_item(CMD_WRITE, PORT_DATA, 8'h00);
		send_item(CMD_READ, PORT_INDEX, 8'h00);
		send_item(CMD_READ, PORT_UNLOCK, 8'h00);
		// wrong key while armed keeps it armed; read disarms
		send_item(CMD_WRITE, PORT_UNLOCK, 8'hB1);
		send_item(CMD_WRITE, PORT_UNLOCK, 8'h12);
		send_item(CMD_READ, PORT_DATA, 8'h00);
		send_item(CMD_READ, PORT_DATA, 8'h00);
		arm_access(8'hFF);
		send_item(CMD_WRITE, PORT_DATA, 8'hFF);
		arm_access(REG_SHADOW_EF);
		send_item(CMD_WRITE, PORT_DATA, 8'h0C);
		arm_access(REG_SHADOW_C);
		send_item(CMD_WRITE, PORT_DATA, 8'hF5);
		wait_drained();

		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= QUIET_ITEMS)
				idle_on = 1'b0;
			if (items_sent > 150 && items_sent < 170) begin
				// fill the port behind a stalled result side
				hold_rsp = 1'b1;
				repeat (8) run_sequence();
				wait_drained();
			end else if (idle_on && $urandom_range(0, 40) == 0) begin
				wait_drained();
			end
			run_sequence();
		end

		req.valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d accesses, %0d reached the register file, %0d SMI pulses.",
			items_sent, unlock_count, smi_count);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/uicp_pkg.sv
rtl/uicp_req_if.sv
rtl/uicp_rsp_if.sv
rtl/uicp_ram.sv
rtl/unlocked_index_config_port_core.sv
tb/uicp_checker.sv
tb/unlocked_index_config_port_core_test.sv
